/* src/tt_pkg.sv */
package tt_pkg;

  // operation codes carried in the func field
  localparam logic [1:0] FUNC_PROBE = 2'd0;
  localparam logic [1:0] FUNC_STORE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // bound kinds, same encoding for stored and requested entries
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_EXACT = 2'd1;
  localparam logic [1:0] KIND_UPPER = 2'd2;
  localparam logic [1:0] KIND_LOWER = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS  = 8;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MATE_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INFINITY_SCORE = 8'd1;

  localparam logic [14:0] MATE_THRESHOLD_RST = 15'd30000;
  localparam logic [14:0] INFINITY_SCORE_RST = 15'd32000;

  typedef struct packed {
    logic        [1:0]  func;
    logic        [63:0] position_key;
    logic signed [15:0] alpha_in;
    logic signed [15:0] beta_in;
    logic signed [7:0]  search_depth;
    logic signed [15:0] score_in;
    logic        [31:0] best_move;
    logic        [1:0]  bound_kind;
    logic        [6:0]  ply_from_root;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic        [31:0] found_move;
    logic        [1:0]  found_kind;
    logic signed [7:0]  found_depth;
    logic signed [15:0] found_score;
    logic signed [15:0] alpha_out;
    logic signed [15:0] beta_out;
  } result_t;

endpackage

/* src/tt_item_if.sv */
interface tt_item_if import tt_pkg::*;;
  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

/* src/tt_result_if.sv */
interface tt_result_if import tt_pkg::*;;
  logic    valid;
  logic    ready;
  result_t result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

/* src/tt_cfg_if.sv */
interface tt_cfg_if import tt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/tt_ram.sv */
module tt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

/* src/tt_mate.sv */
module tt_mate import tt_pkg::*; (
  input  logic signed [15:0] score_i,
  input  logic        [6:0]  ply_i,
  input  logic               undo_i,
  input  logic        [14:0] mate_threshold_i,
  input  logic        [14:0] infinity_score_i,
  output logic signed [15:0] score_o
);

  logic signed [16:0] s_ext;
  logic signed [16:0] mt_ext;
  logic signed [16:0] inf_ext;
  logic               mate_pos;
  logic               mate_neg;
  logic               add_ply;
  logic               sub_ply;
  logic signed [17:0] sum;

  // mate range classification
  always_comb begin
    s_ext    = {score_i[15], score_i};
    mt_ext   = {2'b00, mate_threshold_i};
    inf_ext  = {2'b00, infinity_score_i};
    mate_pos = (s_ext > mt_ext) && (s_ext <= inf_ext);
    mate_neg = (s_ext < -mt_ext) && (s_ext >= -inf_ext);
  end

  // store moves mate scores outward, probe moves them back
  assign add_ply = (mate_pos && !undo_i) || (mate_neg && undo_i);
  assign sub_ply = (mate_neg && !undo_i) || (mate_pos && undo_i);

  always_comb begin
    sum = {{2{score_i[15]}}, score_i};
    if (add_ply) begin
      sum = sum + $signed({11'd0, ply_i});
    end else if (sub_ply) begin
      sum = sum - $signed({11'd0, ply_i});
    end
  end

  // saturate to 16 bits
  always_comb begin
    if (sum > 18'sd32767) begin
      score_o = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      score_o = 16'sh8000;
    end else begin
      score_o = sum[15:0];
    end
  end

endmodule

/* src/transposition_table.sv */
// a probe passes the access, lookup and resolve states before its result is
// registered; store, clear and the unused code 3 skip the lookup state
// one transaction is taken at a time, and a stalled result holds off the next;
// the single-port entry memory is read, then resolved, before the next one
// reset: a clearing pass writes every entry empty, during which no transaction
// is accepted; configuration writes are taken throughout
module transposition_table import tt_pkg::*; #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned MOVE_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tt_item_if.sink           in_i,
  tt_result_if.source       res_o,
  tt_cfg_if.sink            cfg_i
);

  localparam int unsigned DEPTH    = 1 << INDEX_BITS;
  localparam int unsigned TAG_BITS = 64 - INDEX_BITS;

  typedef struct packed {
    logic                 valid;
    logic [TAG_BITS-1:0]  tag;
    logic [MOVE_BITS-1:0] move;
    logic [1:0]           kind;
    logic signed [7:0]    depth;
    logic signed [15:0]   score;
  } entry_t;

  localparam int unsigned ENTRY_BITS = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_LOOKUP,
    ST_RESOLVE
  } state_e;

  state_e                  state_q, state_d;
  logic [INDEX_BITS-1:0]   clr_q;
  item_t                   item_q;
  logic                    res_valid_q;
  result_t                 res_q, res_d;
  logic [14:0]             mate_threshold_q;
  logic [14:0]             infinity_score_q;

  logic                    hit_q;
  logic                    deep_q;
  logic signed [15:0]      v_q;
  entry_t                  found_q;

  logic                    in_fire;
  logic                    out_load;
  logic                    is_probe;
  logic                    ram_we;
  logic [INDEX_BITS-1:0]   ram_addr;
  entry_t                  ram_wdata;
  entry_t                  ram_rdata;
  logic [ENTRY_BITS-1:0]   ram_rdata_raw;

  logic signed [15:0]      mate_score_in;
  logic                    mate_undo;
  logic signed [15:0]      mate_score_out;

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign is_probe  = (item_q.func == FUNC_PROBE);
  assign out_load  = (state_q == ST_RESOLVE) && (!res_valid_q || res_o.ready);

  assign res_o.valid  = res_valid_q;
  assign res_o.result = res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mate_threshold_q <= MATE_THRESHOLD_RST;
      infinity_score_q <= INFINITY_SCORE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MATE_THRESHOLD: mate_threshold_q <= cfg_i.data[14:0];
        CFG_INFINITY_SCORE: infinity_score_q <= cfg_i.data[14:0];
        default: ;
      endcase
    end
  end

  // shared mate shift: store in the access cycle, probe in the lookup cycle
  assign mate_undo     = (state_q == ST_LOOKUP);
  assign mate_score_in = mate_undo ? ram_rdata.score : item_q.score_in;

  tt_mate u_mate (
    .score_i          (mate_score_in),
    .ply_i            (item_q.ply_from_root),
    .undo_i           (mate_undo),
    .mate_threshold_i (mate_threshold_q),
    .infinity_score_i (infinity_score_q),
    .score_o          (mate_score_out)
  );

  // memory port: clearing pass, then store or clear writes and probe reads
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = item_q.position_key[INDEX_BITS-1:0];
    ram_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      ST_ACCESS: begin
        ram_we = (item_q.func == FUNC_STORE) || (item_q.func == FUNC_CLEAR);
        if (item_q.func == FUNC_STORE) begin
          ram_wdata.valid = 1'b1;
          ram_wdata.tag   = item_q.position_key[63:INDEX_BITS];
          ram_wdata.move  = item_q.best_move[MOVE_BITS-1:0];
          ram_wdata.kind  = item_q.bound_kind;
          ram_wdata.depth = item_q.search_depth;
          ram_wdata.score = mate_score_out;
        end
      end
      default: ;
    endcase
  end

  tt_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:   if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:    if (in_fire) state_d = ST_ACCESS;
      ST_ACCESS:  state_d = is_probe ? ST_LOOKUP : ST_RESOLVE;
      ST_LOOKUP:  state_d = ST_RESOLVE;
      ST_RESOLVE: if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (out_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result: found entry and tightened window on a probe hit, else the window as given
  always_comb begin
    res_d             = '0;
    res_d.alpha_out   = item_q.alpha_in;
    res_d.beta_out    = item_q.beta_in;
    if (is_probe && hit_q) begin
      res_d.hit         = 1'b1;
      res_d.found_move  = 32'(found_q.move);
      res_d.found_kind  = found_q.kind;
      res_d.found_depth = found_q.depth;
      res_d.found_score = found_q.score;
      if (deep_q) begin
        case (found_q.kind)
          KIND_EXACT: begin
            res_d.alpha_out = v_q;
            res_d.beta_out  = v_q;
          end
          KIND_UPPER: if (v_q <= item_q.alpha_in) res_d.beta_out = item_q.alpha_in;
          KIND_LOWER: if (v_q >= item_q.beta_in) res_d.alpha_out = item_q.beta_in;
          default: ;
        endcase
      end
    end
  end

  // transaction and lookup payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_i.item;
    end
    if (state_q == ST_LOOKUP) begin
      hit_q   <= ram_rdata.valid && (ram_rdata.tag == item_q.position_key[63:INDEX_BITS]);
      deep_q  <= (ram_rdata.depth >= item_q.search_depth);
      v_q     <= mate_score_out;
      found_q <= ram_rdata;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  // one transaction in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("transaction accepted while another is in flight");

  // the memory is written only by the clearing pass or a store or clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR) ||
               ((state_q == ST_ACCESS) && !is_probe))
    else $error("unexpected table write");

  // clearing pass covers every entry before leaving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) && (clr_q != '1) |=> (state_q == ST_CLEAR))
    else $error("clearing pass ended early");

  // a result load from the resolve step sets the result valid and returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> res_valid_q && (state_q == ST_IDLE))
    else $error("result load without transfer to idle");

endmodule

/* verif/tt_check_pkg.sv */
`timescale 1ns / 100ps
package tt_check_pkg;
  import tt_pkg::*;

  localparam int unsigned TABLE_INDEX_BITS = 16;

  // one table entry as the search code sees it
  typedef struct {
    logic        [63:0] key;
    logic        [31:0] move;
    logic        [1:0]  kind;
    logic signed [7:0]  depth;
    logic signed [15:0] score;
  } slot_t;

  class tt_lookup_checker;
    // occupied entries only, a missing index is an empty entry
    slot_t       slots[bit [TABLE_INDEX_BITS-1:0]];
    result_t     expected_responses[$];
    int unsigned mate_thr;
    int unsigned inf_score;
    int unsigned errors;

    function new();
      mate_thr  = int'(MATE_THRESHOLD_RST);
      inf_score = int'(INFINITY_SCORE_RST);
      errors    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == CFG_MATE_THRESHOLD) begin
        mate_thr = int'(data[14:0]);
      end else if (idx == CFG_INFINITY_SCORE) begin
        inf_score = int'(data[14:0]);
      end
    endfunction

    function int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // +1 inside the positive mate band, -1 inside the negative one
    function int mate_side(int s);
      int mt;
      int lim;
      mt  = int'(mate_thr);
      lim = int'(inf_score);
      if (s > mt && s <= lim) return 1;
      if (s < -mt && s >= -lim) return -1;
      return 0;
    endfunction

    function result_t predict_response(item_t it);
      result_t               r;
      slot_t                 e;
      bit [TABLE_INDEX_BITS-1:0] idx;
      int                    v;
      int                    ply;
      r           = '0;
      r.alpha_out = it.alpha_in;
      r.beta_out  = it.beta_in;
      idx         = it.position_key[TABLE_INDEX_BITS-1:0];
      ply         = int'(it.ply_from_root);
      case (it.func)
        FUNC_PROBE: begin
          if (slots.exists(idx) && slots[idx].key == it.position_key) begin
            e             = slots[idx];
            r.hit         = 1'b1;
            r.found_move  = e.move;
            r.found_kind  = e.kind;
            r.found_depth = e.depth;
            r.found_score = e.score;
            // deep enough: undo the mate shift and narrow the window
            if (e.depth >= it.search_depth) begin
              v = clamp16(int'(e.score) - mate_side(int'(e.score)) * ply);
              if (e.kind == KIND_EXACT) begin
                r.alpha_out = 16'(v);
                r.beta_out  = 16'(v);
              end else if (e.kind == KIND_UPPER && v <= int'(it.alpha_in)) begin
                r.beta_out = it.alpha_in;
              end else if (e.kind == KIND_LOWER && v >= int'(it.beta_in)) begin
                r.alpha_out = it.beta_in;
              end
            end
          end
        end
        FUNC_STORE: begin
          e.key   = it.position_key;
          e.move  = it.best_move;
          e.kind  = it.bound_kind;
          e.depth = it.search_depth;
          e.score = 16'(clamp16(int'(it.score_in) + mate_side(int'(it.score_in)) * ply));
          slots[idx] = e;
        end
        FUNC_CLEAR: begin
          slots.delete(idx);
        end
        default: begin
        end
      endcase
      return r;
    endfunction

    function void record_request(item_t it);
      expected_responses.push_back(predict_response(it));
    endfunction

    function int unsigned pending();
      return expected_responses.size();
    endfunction

    function void compare_field(string name, longint want_v, longint got_v);
      if (want_v != got_v) begin
        errors++;
        $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      end
    endfunction

    function void check_response(result_t got);
      result_t want;
      if (expected_responses.size() == 0) begin
        errors++;
        $error("response transaction with no request outstanding");
        return;
      end
      want = expected_responses.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("found_move", want.found_move, got.found_move);
      compare_field("found_kind", want.found_kind, got.found_kind);
      compare_field("found_depth", want.found_depth, got.found_depth);
      compare_field("found_score", want.found_score, got.found_score);
      compare_field("alpha_out", want.alpha_out, got.alpha_out);
      compare_field("beta_out", want.beta_out, got.beta_out);
    endfunction
  endclass

endpackage

/* verif/transposition_table_tb.sv */
`timescale 1ns / 100ps
module transposition_table_tb;
  import tt_pkg::*;
  import tt_check_pkg::*;

  localparam logic [1:0]              FUNC_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 8'd2;
  localparam int unsigned STALL_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 105;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned POOL_SIZE     = 12;

  logic clk_i = 1'b0;
  logic rst_ni;

  tt_item_if   in_if ();
  tt_result_if res_if ();
  tt_cfg_if    cfg_if ();

  transposition_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  tt_lookup_checker lookup_checker;
  bit               idle_on;
  int unsigned      cur_thr;
  int unsigned      cur_inf;
  logic [63:0]      key_pool[POOL_SIZE];
  int unsigned      quiet_cycles = 0;
  int unsigned      res_stall = 0;

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // response side: check each transaction, stall in short random bursts while idling is on
  always @(posedge clk_i) begin
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      lookup_checker.check_response(res_if.result);
    end
    if (res_stall != 0) begin
      res_stall--;
      res_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res_stall = $urandom_range(0, 3);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("transposition_table verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // leaves valid high; the caller lowers it before any pause
  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [14:0] value);
    logic [CFG_DATA_BITS-1:0] word;
    word = {1'($urandom_range(0, 1)), value};
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= word;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    lookup_checker.set_register(idx, word);
  endtask

  task automatic apply_settings(int unsigned thr, int unsigned lim);
    write_register(CFG_MATE_THRESHOLD, 15'(thr));
    write_register(CFG_INFINITY_SCORE, 15'(lim));
    cfg_if.valid <= 1'b0;
    cur_thr = thr;
    cur_inf = lim;
  endtask

  // leaves valid high so back-to-back requests need no gap
  task automatic send_item(item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.item  <= it;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    lookup_checker.record_request(it);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (lookup_checker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic item_t make_item(logic [1:0] func, logic [63:0] key, int alpha, int beta,
                                      int depth, int score, logic [31:0] move,
                                      logic [1:0] kind, int ply);
    item_t it;
    it.func          = func;
    it.position_key  = key;
    it.alpha_in      = 16'(alpha);
    it.beta_in       = 16'(beta);
    it.search_depth  = 8'(depth);
    it.score_in      = 16'(score);
    it.best_move     = move;
    it.bound_kind    = kind;
    it.ply_from_root = 7'(ply);
    return it;
  endfunction

  // scores cluster on the mate band edges of the current settings, with some uniform, near-zero and full-scale picks
  function automatic int pick_score();
    case ($urandom_range(0, 6))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return int'(cur_thr) + int'($urandom_range(0, 6)) - 3;
      2: return -int'(cur_thr) + int'($urandom_range(0, 6)) - 3;
      3: return int'(cur_inf) + int'($urandom_range(0, 6)) - 3;
      4: return -int'(cur_inf) + int'($urandom_range(0, 6)) - 3;
      5: return int'($urandom_range(0, 400)) - 200;
      default: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    endcase
  endfunction

  function automatic void refill_pool();
    logic [63:0] k;
    // pairs share an index but differ above it
    for (int i = 0; i < POOL_SIZE; i += 2) begin
      k               = {$urandom, $urandom};
      key_pool[i]     = k;
      key_pool[i + 1] = {~k[63:32], 16'($urandom_range(0, 65535)) ^ k[31:16], k[15:0]};
    end
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    sel;
    int    alpha;
    int    beta;
    int    depth;
    if ($urandom_range(0, 9) < 8) begin
      it.position_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else begin
      it.position_key = {$urandom, $urandom};
    end
    sel = $urandom_range(0, 99);
    if (sel < 50) it.func = FUNC_PROBE;
    else if (sel < 86) it.func = FUNC_STORE;
    else if (sel < 97) it.func = FUNC_CLEAR;
    else it.func = FUNC_UNUSED;
    alpha = ($urandom_range(0, 1) != 0) ? pick_score() : int'($urandom_range(0, 65535));
    beta  = ($urandom_range(0, 1) != 0) ? pick_score() : int'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) < 6) depth = int'($urandom_range(0, 12)) - 4;
    else depth = int'($urandom_range(0, 255));
    it.alpha_in      = 16'(alpha);
    it.beta_in       = 16'(beta);
    it.search_depth  = 8'(depth);
    it.score_in      = 16'(pick_score());
    it.best_move     = $urandom;
    it.bound_kind    = 2'($urandom_range(0, 3));
    it.ply_from_root = 7'($urandom_range(0, 127));
    return it;
  endfunction

  initial begin
    logic [63:0] k1;
    logic [63:0] k1_alias;
    logic [63:0] k2;
    logic [63:0] k3;
    logic [63:0] k4;
    logic [63:0] k5;
    logic [63:0] k6;
    int unsigned thr_set[NUM_PHASES];
    int unsigned inf_set[NUM_PHASES];

    lookup_checker = new();
    idle_on        = 1'b1;
    cur_thr        = int'(MATE_THRESHOLD_RST);
    cur_inf        = int'(INFINITY_SCORE_RST);
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.item     <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= '0;
    cfg_if.data    <= '0;

    k1       = 64'h0123_4567_89ab_0011;
    k1_alias = 64'hfedc_ba98_7654_0011;
    k2       = 64'h8000_0000_0000_0022;
    k3       = 64'h5555_aaaa_5555_0033;
    k4       = 64'h0f0f_f0f0_0f0f_0044;
    k5       = 64'h7fff_0000_ffff_0055;
    k6       = 64'h3c3c_c3c3_1234_0066;

    thr_set = '{0, 32767, 0, 120, 0, 32000};
    inf_set = '{32767, 32767, 0, 20000, 0, 30000};
    thr_set[4] = $urandom_range(0, 32767);
    inf_set[4] = $urandom_range(thr_set[4], 32767);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register writes are taken during the clearing pass
    write_register(CFG_UNUSED_IDX, 15'($urandom));
    apply_settings(30000, 32000);

    // directed: empty entries, every bound kind, mate shifts
    send_item(make_item(FUNC_PROBE, 64'd0, 0, 0, -128, 0, 0, KIND_NONE, 0));
    send_item(make_item(FUNC_PROBE, k1, -50, 50, 0, 0, 0, KIND_NONE, 0));
    send_item(make_item(FUNC_STORE, k1, 0, 0, 5, 100, 32'h1234_5678, KIND_EXACT, 3));
    send_item(make_item(FUNC_PROBE, k1, -50, 50, 5, 0, 0, KIND_NONE, 3));
    send_item(make_item(FUNC_PROBE, k1, -50, 50, 6, 0, 0, KIND_NONE, 3));
    send_item(make_item(FUNC_PROBE, k1_alias, -50, 50, -128, 0, 0, KIND_NONE, 3));
    send_item(make_item(FUNC_STORE, k2, 0, 0, 127, 30500, 32'h0000_0001, KIND_UPPER, 10));
    send_item(make_item(FUNC_PROBE, k2, 32767, 32767, -128, 0, 0, KIND_NONE, 10));
    send_item(make_item(FUNC_PROBE, k2, -32768, 32767, -128, 0, 0, KIND_NONE, 10));
    send_item(make_item(FUNC_STORE, k3, 0, 0, -128, -30500, 32'h8000_0000, KIND_LOWER, 20));
    send_item(make_item(FUNC_PROBE, k3, -32768, -32768, -128, 0, 0, KIND_NONE, 20));
    send_item(make_item(FUNC_PROBE, k3, -32768, 32767, -128, 0, 0, KIND_NONE, 20));
    send_item(make_item(FUNC_STORE, k4, 0, 0, 1, 32000, 32'haaaa_5555, KIND_EXACT, 127));
    send_item(make_item(FUNC_PROBE, k4, -10, 10, 1, 0, 0, KIND_NONE, 0));
    send_item(make_item(FUNC_STORE, k5, 0, 0, 1, -32000, 32'h5555_aaaa, KIND_EXACT, 127));
    send_item(make_item(FUNC_PROBE, k5, -10, 10, 0, 0, 0, KIND_NONE, 5));
    send_item(make_item(FUNC_STORE, k6, 0, 0, 3, 30001, 32'hffff_ffff, KIND_NONE, 1));
    send_item(make_item(FUNC_PROBE, k6, -32768, 32767, 3, 0, 0, KIND_NONE, 1));
    send_item(make_item(FUNC_CLEAR, k1, 0, 0, 0, 0, 0, KIND_NONE, 0));
    send_item(make_item(FUNC_PROBE, k1, -50, 50, -128, 0, 0, KIND_NONE, 0));
    send_item(make_item(FUNC_UNUSED, k2, 1, 2, 3, 4, 32'h0bad_0bad, KIND_EXACT, 9));
    send_item(make_item(FUNC_PROBE, k2, 32767, 32767, -128, 0, 0, KIND_NONE, 10));
    send_item(make_item(FUNC_STORE, '1, 32767, 32767, 127, 32767, '1, KIND_LOWER, 127));
    send_item(make_item(FUNC_PROBE, '1, 32767, -32768, -128, 32767, '1, KIND_LOWER, 127));
    send_item(make_item(FUNC_STORE, 64'd0, 0, 0, 0, -7, 32'h0000_ffff, KIND_EXACT, 2));
    send_item(make_item(FUNC_PROBE, 64'd0, -32768, 32767, 0, 0, 0, KIND_NONE, 2));
    send_item(make_item(FUNC_CLEAR, 64'd0, 0, 0, 0, 0, 0, KIND_NONE, 0));

    // random phases, one register setting each, no idling in the last
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      apply_settings(thr_set[p], inf_set[p]);
      refill_pool();
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender until the table has answered everything
        if (p == 1 && n == PHASE_ITEMS / 2) wait_drain();
        send_item(random_item());
      end
    end

    wait_drain();
    if (lookup_checker.errors == 0 && lookup_checker.pending() == 0) begin
      $display("transposition_table verification clean");
    end else begin
      $display("transposition_table verification failed");
    end
    $finish;
  end

endmodule
